// ===== sv/gtpp_pkg.sv =====
// Package: widths, codes and stage record types of the gnomonic projection unit.
`default_nettype none
package gtpp_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned PP_W      = 64;
  localparam int unsigned NY_W      = 96;
  localparam int unsigned DEN_W     = 96;
  localparam int unsigned Q_W       = 33;
  localparam int unsigned REM_W     = DEN_W + Q_W;
  localparam int unsigned SQ_STEPS  = PP_W / 2;
  localparam int unsigned DIV_STEPS = Q_W;
  localparam int unsigned NX_SHIFT  = 54;
  localparam int unsigned NY_SHIFT  = 24;

  // Register indexes of the write port
  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_CENTER_Z = 2'd2;

  localparam logic [DATA_W-1:0] CENTER_X_RESET = 32'h4000_0000;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [1:0] ST_SAT      = 2'd2;

  localparam logic [DATA_W-1:0] POS_MAX = 32'h7FFF_FFFF;
  localparam logic [DATA_W-1:0] NEG_MAX = 32'h8000_0000;

  // Ray as packed on the input bus, x in the lowest bits
  typedef struct packed {
    logic signed [31:0] pz;
    logic signed [31:0] py;
    logic signed [31:0] px;
  } in_t;

  typedef struct packed {
    logic signed [63:0] cxpx;
    logic signed [63:0] cypy;
    logic signed [63:0] pzcz;
    logic signed [63:0] cxpy;
    logic signed [63:0] cypx;
    logic signed [63:0] cxx;
    logic signed [63:0] cyy;
    logic signed [31:0] pz;
  } prod_t;

  typedef struct packed {
    logic [PP_W-1:0]    pp;
    logic signed [64:0] cp;
    logic signed [65:0] d;
    logic signed [64:0] nx;
    logic signed [31:0] pz;
  } sum_t;

  typedef struct packed {
    logic signed [64:0] m1;
    logic signed [64:0] m2;
    logic signed [64:0] m3;
    logic signed [64:0] m4;
    logic [PP_W-1:0]    pp;
    logic signed [65:0] d;
    logic signed [64:0] nx;
  } part_t;

  typedef struct packed {
    logic signed [96:0] a;
    logic signed [96:0] b;
    logic [PP_W-1:0]    pp;
    logic signed [65:0] d;
    logic signed [64:0] nx;
  } half_t;

  typedef struct packed {
    logic [PP_W-1:0] pp;
    logic [63:0]     nxm;
    logic [63:0]     dm;
    logic [NY_W-1:0] nym;
    logic            negx;
    logic            negy;
  } mag_t;

  typedef struct packed {
    logic [PP_W-1:0] rad;
    logic [PP_W-1:0] res;
    logic [63:0]     nxm;
    logic [63:0]     dm;
    logic [NY_W-1:0] nym;
    logic            negx;
    logic            negy;
  } sq_t;

  typedef struct packed {
    logic [63:0]     pl;
    logic [63:0]     ph;
    logic            zero;
    logic [63:0]     nxm;
    logic [NY_W-1:0] nym;
    logic            negx;
    logic            negy;
  } mul_t;

  typedef struct packed {
    logic [DEN_W-1:0] den;
    logic             zero;
    logic [63:0]      nxm;
    logic [NY_W-1:0]  nym;
    logic             negx;
    logic             negy;
  } den_t;

  typedef struct packed {
    logic [REM_W-1:0] remx;
    logic [REM_W-1:0] remy;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   qx;
    logic [Q_W-1:0]   qy;
    logic             satx;
    logic             saty;
    logic             zero;
    logic             negx;
    logic             negy;
  } div_t;

  typedef struct packed {
    logic [DATA_W-1:0] plane_x;
    logic [DATA_W-1:0] plane_y;
    logic [1:0]        status;
  } fin_t;

  typedef struct packed {
    logic [DATA_W-1:0] val;
    logic              sat;
  } coord_t;

endpackage
`default_nettype wire

// ===== sv/gnomonic_tangent_plane_projection_unit.sv =====
// Top level: pipelined gnomonic projection of a direction onto a tangent plane.
//
// Usage
//   Config: write center_x/y/z (Q2.30) through cfg_we_i/cfg_idx_i/cfg_wdata_i while the
//   block holds no item. Reset sets the centre to (1.0, 0, 0). Index 3 is ignored.
//   Input stream: one ray per item, s_axis_tdata = {ray_z, ray_y, ray_x}, Q2.30.
//   Output stream: m_axis_tdata = {plane_y, plane_x} in Q8.24, m_axis_tuser = status
//   (ok, zero denominator with zero coordinates, or saturated).
// Throughput and pipeline
//   One item per cycle while the skid register is empty. A result passes through the
//   input register, five product and sum stages, a 32 step square root (one result bit
//   per stage), the denominator multiply, and two 33 step restoring dividers running
//   side by side, one quotient bit per stage.
// Flow control
//   The whole pipe advances together, gated only by a registered skid flag. When
//   the receiver stalls, the output register holds its item and one more item
//   drops into the skid register; only then does s_axis_tready fall, so no item
//   is lost or repeated. Reset clears all valid bits and the skid flag.
`default_nettype none
module gnomonic_tangent_plane_projection_unit
  import gtpp_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_idx_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [95:0] s_axis_tdata,   // ray_x, ray_y, ray_z
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,   // plane_x, plane_y
  output logic [1:0]       m_axis_tuser    // status
);

  localparam int unsigned SQ_BASE  = 6;
  localparam int unsigned MUL_ST   = SQ_BASE + SQ_STEPS;
  localparam int unsigned DEN_ST   = MUL_ST + 1;
  localparam int unsigned DVI_ST   = DEN_ST + 1;
  localparam int unsigned FIN_ST   = DVI_ST + DIV_STEPS + 1;
  localparam int unsigned NST      = FIN_ST + 1;

  logic signed [31:0] cx_q, cy_q, cz_q;

  logic           adv;
  logic [NST-1:0] vld_q;
  logic           out_vld_q, skid_vld_q;
  fin_t           out_q, skid_q;

  in_t   in_q;
  prod_t prod_d, prod_q;
  sum_t  sum_d, sum_q;
  part_t part_d, part_q;
  half_t half_d, half_q;
  mag_t  mag_d, mag_q;
  sq_t   sq_d [SQ_STEPS];
  sq_t   sq_q [SQ_STEPS];
  mul_t  mul_d, mul_q;
  den_t  den_d, den_q;
  div_t  dvi_d, dvi_q;
  div_t  dv_d [DIV_STEPS];
  div_t  dv_q [DIV_STEPS];
  fin_t  fin_d, fin_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= CENTER_X_RESET;
      cy_q <= '0;
      cz_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_CENTER_X: cx_q <= cfg_wdata_i;
        CFG_CENTER_Y: cy_q <= cfg_wdata_i;
        CFG_CENTER_Z: cz_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Advance the whole pipe unless the skid register holds an item
  assign adv           = !skid_vld_q;
  assign s_axis_tready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // Products of centre and ray
  always_comb begin
    prod_d.cxpx = $signed(cx_q) * $signed(in_q.px);
    prod_d.cypy = $signed(cy_q) * $signed(in_q.py);
    prod_d.pzcz = $signed(in_q.pz) * $signed(cz_q);
    prod_d.cxpy = $signed(cx_q) * $signed(in_q.py);
    prod_d.cypx = $signed(cy_q) * $signed(in_q.px);
    prod_d.cxx  = $signed(cx_q) * $signed(cx_q);
    prod_d.cyy  = $signed(cy_q) * $signed(cy_q);
    prod_d.pz   = in_q.pz;
  end

  // Perpendicular norm, dot terms and x numerator
  always_comb begin
    sum_d.pp = prod_q.cxx + prod_q.cyy;
    sum_d.cp = 65'($signed(prod_q.cxpx)) + 65'($signed(prod_q.cypy));
    sum_d.d  = 66'($signed(prod_q.cxpx)) + 66'($signed(prod_q.cypy))
             + 66'($signed(prod_q.pzcz));
    sum_d.nx = 65'($signed(prod_q.cxpy)) - 65'($signed(prod_q.cypx));
    sum_d.pz = prod_q.pz;
  end

  // Partial products of pz*pp and cz*cp, split at bit 32
  always_comb begin
    part_d.m1 = $signed(sum_q.pz) * $signed({1'b0, sum_q.pp[31:0]});
    part_d.m2 = $signed(sum_q.pz) * $signed({1'b0, sum_q.pp[63:32]});
    part_d.m3 = $signed(cz_q) * $signed({1'b0, sum_q.cp[31:0]});
    part_d.m4 = $signed(cz_q) * $signed(sum_q.cp[64:32]);
    part_d.pp = sum_q.pp;
    part_d.d  = sum_q.d;
    part_d.nx = sum_q.nx;
  end

  always_comb begin
    half_d.a  = $signed({part_q.m2, 32'b0}) + 97'($signed(part_q.m1));
    half_d.b  = $signed({part_q.m4, 32'b0}) + 97'($signed(part_q.m3));
    half_d.pp = part_q.pp;
    half_d.d  = part_q.d;
    half_d.nx = part_q.nx;
  end

  // y numerator, then magnitudes and quotient signs
  always_comb begin
    logic signed [96:0] ny;
    ny          = $signed(half_q.a) - $signed(half_q.b);
    mag_d.pp    = half_q.pp;
    mag_d.nxm   = half_q.nx[64] ? 64'(-half_q.nx) : half_q.nx[63:0];
    mag_d.dm    = half_q.d[65] ? 64'(-half_q.d) : half_q.d[63:0];
    mag_d.nym   = ny[96] ? 96'(-ny) : ny[95:0];
    mag_d.negx  = half_q.nx[64] ^ half_q.d[65];
    mag_d.negy  = ny[96] ^ half_q.d[65];
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      in_q   <= s_axis_tdata;
      prod_q <= prod_d;
      sum_q  <= sum_d;
      part_q <= part_d;
      half_q <= half_d;
      mag_q  <= mag_d;
    end
  end

  // Integer square root of pp, one result bit per stage
  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    localparam logic [PP_W-1:0] SQ_BIT = PP_W'(1) << (2 * (SQ_STEPS - 1 - k));
    sq_t src;
    if (k == 0) begin : g_first
      always_comb begin
        src      = '0;
        src.rad  = mag_q.pp;
        src.nxm  = mag_q.nxm;
        src.dm   = mag_q.dm;
        src.nym  = mag_q.nym;
        src.negx = mag_q.negx;
        src.negy = mag_q.negy;
      end
    end else begin : g_next
      assign src = sq_q[k-1];
    end
    always_comb begin
      logic [PP_W-1:0] trial;
      trial    = src.res + SQ_BIT;
      sq_d[k]  = src;
      if (src.rad >= trial) begin
        sq_d[k].rad = src.rad - trial;
        sq_d[k].res = (src.res >> 1) + SQ_BIT;
      end else begin
        sq_d[k].res = src.res >> 1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        sq_q[k] <= sq_d[k];
      end
    end
  end

  // Denominator sqrt(pp) * |d|, split at bit 32 of |d|
  always_comb begin
    logic [31:0] s;
    s          = sq_q[SQ_STEPS-1].res[31:0];
    mul_d.pl   = s * sq_q[SQ_STEPS-1].dm[31:0];
    mul_d.ph   = s * sq_q[SQ_STEPS-1].dm[63:32];
    mul_d.zero = (s == '0) || (sq_q[SQ_STEPS-1].dm == '0);
    mul_d.nxm  = sq_q[SQ_STEPS-1].nxm;
    mul_d.nym  = sq_q[SQ_STEPS-1].nym;
    mul_d.negx = sq_q[SQ_STEPS-1].negx;
    mul_d.negy = sq_q[SQ_STEPS-1].negy;
  end

  always_comb begin
    den_d.den  = DEN_W'({mul_q.ph, 32'b0}) + DEN_W'(mul_q.pl);
    den_d.zero = mul_q.zero;
    den_d.nxm  = mul_q.nxm;
    den_d.nym  = mul_q.nym;
    den_d.negx = mul_q.negx;
    den_d.negy = mul_q.negy;
  end

  // Scale numerators; a quotient of 2^Q_W or more saturates
  always_comb begin
    logic [REM_W-1:0] top;
    top        = REM_W'(den_q.den) << Q_W;
    dvi_d.remx = REM_W'(den_q.nxm) << NX_SHIFT;
    dvi_d.remy = REM_W'(den_q.nym) << NY_SHIFT;
    dvi_d.den  = den_q.den;
    dvi_d.qx   = '0;
    dvi_d.qy   = '0;
    dvi_d.satx = dvi_d.remx >= top;
    dvi_d.saty = dvi_d.remy >= top;
    dvi_d.zero = den_q.zero;
    dvi_d.negx = den_q.negx;
    dvi_d.negy = den_q.negy;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mul_q <= mul_d;
      den_q <= den_d;
      dvi_q <= dvi_d;
    end
  end

  // Restoring dividers, quotient bit Q_W-1-i at stage i
  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_dv
    localparam int unsigned QB = DIV_STEPS - 1 - i;
    div_t src;
    if (i == 0) begin : g_first
      assign src = dvi_q;
    end else begin : g_next
      assign src = dv_q[i-1];
    end
    always_comb begin
      logic [REM_W-1:0] sub;
      sub      = REM_W'(src.den) << QB;
      dv_d[i]  = src;
      if (src.remx >= sub) begin
        dv_d[i].remx   = src.remx - sub;
        dv_d[i].qx[QB] = 1'b1;
      end
      if (src.remy >= sub) begin
        dv_d[i].remy   = src.remy - sub;
        dv_d[i].qy[QB] = 1'b1;
      end
    end
    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_q[i] <= dv_d[i];
      end
    end
  end

  // Apply sign and clamp to the Q8.24 range
  function automatic coord_t finish(logic [Q_W-1:0] q, logic neg, logic big);
    coord_t r;
    r.sat = 1'b0;
    if (!neg) begin
      if (big || q > Q_W'(POS_MAX)) begin
        r.val = POS_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = q[DATA_W-1:0];
      end
    end else begin
      if (big || q > Q_W'(NEG_MAX)) begin
        r.val = NEG_MAX;
        r.sat = 1'b1;
      end else begin
        r.val = DATA_W'(~q[DATA_W-1:0] + 1'b1);
      end
    end
    return r;
  endfunction

  always_comb begin
    coord_t fx, fy;
    fx = finish(dv_q[DIV_STEPS-1].qx, dv_q[DIV_STEPS-1].negx, dv_q[DIV_STEPS-1].satx);
    fy = finish(dv_q[DIV_STEPS-1].qy, dv_q[DIV_STEPS-1].negy, dv_q[DIV_STEPS-1].saty);
    if (dv_q[DIV_STEPS-1].zero) begin
      fin_d.plane_x = '0;
      fin_d.plane_y = '0;
      fin_d.status  = ST_ZERO_DEN;
    end else begin
      fin_d.plane_x = fx.val;
      fin_d.plane_y = fy.val;
      fin_d.status  = (fx.sat || fy.sat) ? ST_SAT : ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      fin_q <= fin_d;
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else if (!out_vld_q || m_axis_tready) begin
      out_vld_q  <= skid_vld_q || (adv && vld_q[FIN_ST]);
      skid_vld_q <= 1'b0;
    end else if (adv && vld_q[FIN_ST]) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_vld_q || m_axis_tready) begin
      out_q <= skid_vld_q ? skid_q : fin_q;
    end else if (adv && vld_q[FIN_ST]) begin
      skid_q <= fin_q;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.plane_y, out_q.plane_x};
  assign m_axis_tuser  = out_q.status;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q) else $error("skid entry held without output item");
  a_skid_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> !s_axis_tready) else $error("input open while skid is full");
  a_zero_den_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_q.status == ST_ZERO_DEN) |-> (m_axis_tdata == '0))
    else $error("zero denominator item carries nonzero coordinates");
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q |-> (out_q.status == ST_OK || out_q.status == ST_ZERO_DEN ||
                   out_q.status == ST_SAT)) else $error("bad status code");
  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !m_axis_tready && !skid_vld_q && vld_q[FIN_ST]) |=> skid_vld_q)
    else $error("finished item dropped while output stalled");
`endif

endmodule
`default_nettype wire

// ===== bench/tb.sv =====
// Testbench for the gnomonic tangent plane projection unit, checked against its own predictor.
`timescale 1ns / 100ps
`default_nettype none
module tb;
  import gtpp_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // unused index, writes are dropped
  localparam int unsigned PIPE_LAT = 80;

  typedef struct packed {
    logic [31:0] rz;
    logic [31:0] ry;
    logic [31:0] rx;
  } ray_t;

  typedef struct packed {
    logic [31:0] py;
    logic [31:0] px;
    logic [1:0]  st;
  } plane_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = '0;
  logic [31:0] cfg_wdata_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [95:0] s_axis_tdata = '0;   // ray_x, ray_y, ray_z
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;        // plane_x, plane_y
  logic [1:0]  m_axis_tuser;        // status

  gnomonic_tangent_plane_projection_unit uut (.*);

  always #6 clk_i = ~clk_i;

  // Shadow copy of the centre registers
  logic [31:0] ctr_x = CENTER_X_RESET, ctr_y = '0, ctr_z = '0;

  ray_t   rays_pending[$];
  plane_t planes_due[$];
  int     n_err = 0;
  int     send_idle = 0, recv_idle = 0;
  int     hold_left = 0;
  logic   took = 1'b0;

  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0]  r;
    logic [127:0] t;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      t = r | (64'd1 << i);
      if (t * t <= {64'd0, v}) r = t[63:0];
    end
    return r;
  endfunction

  // Clamp a magnitude quotient to a signed 32-bit coordinate
  function automatic logic [31:0] clamp(logic [191:0] q, logic neg, inout logic sat);
    if (!neg) begin
      if (q > 192'h7FFF_FFFF) begin
        sat = 1'b1;
        return POS_MAX;
      end
      return q[31:0];
    end
    if (q > 192'h8000_0000) begin
      sat = 1'b1;
      return NEG_MAX;
    end
    return 32'd0 - q[31:0];
  endfunction

  function automatic plane_t project(ray_t r);
    logic signed [191:0] cx, cy, cz, px, py, pz, pp, cp, d, nx, ny;
    logic [191:0] s, den, dm, nxm, nym;
    logic sat;
    plane_t o;
    cx = {{160{ctr_x[31]}}, ctr_x};
    cy = {{160{ctr_y[31]}}, ctr_y};
    cz = {{160{ctr_z[31]}}, ctr_z};
    px = {{160{r.rx[31]}}, r.rx};
    py = {{160{r.ry[31]}}, r.ry};
    pz = {{160{r.rz[31]}}, r.rz};
    pp = cx * cx + cy * cy;
    cp = cx * px + cy * py;
    d  = cp + pz * cz;
    nx = cx * py - cy * px;
    ny = pz * pp - cz * cp;
    s  = {128'd0, root_floor(pp[63:0])};
    o  = '0;
    if (s == 0 || d == 0) begin
      o.st = ST_ZERO_DEN;
      return o;
    end
    dm  = d[191] ? -d : d;
    nxm = nx[191] ? -nx : nx;
    nym = ny[191] ? -ny : ny;
    den = s * dm;
    sat = 1'b0;
    o.px = clamp((nxm << NX_SHIFT) / den, nx[191] != d[191], sat);
    o.py = clamp((nym << NY_SHIFT) / den, ny[191] != d[191], sat);
    o.st = sat ? ST_SAT : ST_OK;
    return o;
  endfunction

  // Driver: advance to the next ray once the current one is taken
  always @(negedge clk_i) begin
    if (rst_ni && (!s_axis_tvalid || took)) begin
      if (rays_pending.size() > 0 && $urandom_range(99) >= send_idle) begin
        s_axis_tdata  <= rays_pending.pop_front();
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls, plus a long hold-off when requested
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= rst_ni && ($urandom_range(99) >= recv_idle);
    end
  end

  // Record accepted rays and check delivered results
  always @(posedge clk_i) begin
    plane_t got, want;
    took <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) planes_due.push_back(project(s_axis_tdata));
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tdata[63:32], m_axis_tdata[31:0], m_axis_tuser};
      if (planes_due.size() == 0) begin
        n_err++;
        $display("%0t unexpected item: x=%h y=%h st=%0d", $time, got.px, got.py, got.st);
      end else begin
        want = planes_due.pop_front();
        if (got.px !== want.px) begin
          n_err++;
          $display("%0t plane_x exp %h got %h", $time, want.px, got.px);
        end
        if (got.py !== want.py) begin
          n_err++;
          $display("%0t plane_y exp %h got %h", $time, want.py, got.py);
        end
        if (got.st !== want.st) begin
          n_err++;
          $display("%0t status exp %0d got %0d", $time, want.st, got.st);
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_X: ctr_x = val;
      CFG_CENTER_Y: ctr_y = val;
      CFG_CENTER_Z: ctr_z = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    while (rays_pending.size() > 0 || s_axis_tvalid || planes_due.size() > 0) @(posedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Component in Q2.30: mostly unit range, sometimes any pattern, sometimes tiny
  function automatic logic [31:0] rnd_comp();
    int k;
    k = $urandom_range(9);
    if (k < 6) return 32'($urandom_range(32'h8000_0000)) - 32'h4000_0000;
    if (k < 8) return $urandom;
    return 32'($urandom_range(64)) - 32'd32;
  endfunction

  task automatic push_random(int n);
    ray_t r;
    for (int i = 0; i < n; i++) begin
      r.rx = rnd_comp();
      r.ry = rnd_comp();
      r.rz = rnd_comp();
      // sometimes aim a ray along the centre so results stay small
      if ($urandom_range(3) == 0) begin
        r.rx = ctr_x + 32'($urandom_range(2000)) - 32'd1000;
        r.ry = ctr_y + 32'($urandom_range(2000)) - 32'd1000;
        r.rz = ctr_z;
      end
      rays_pending.push_back(r);
    end
  endtask

  initial begin
    logic [31:0] one, mone;
    one  = 32'h4000_0000;
    mone = 32'hC000_0000;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    send_idle = 21;
    recv_idle = 64;

    // Directed rays at the reset centre (1, 0, 0)
    rays_pending.push_back('{rz: 0, ry: 0, rx: one});            // the centre itself
    rays_pending.push_back('{rz: one, ry: one, rx: one});
    rays_pending.push_back('{rz: 0, ry: one, rx: 0});            // point at infinity
    rays_pending.push_back('{rz: mone, ry: mone, rx: mone});     // behind the centre
    rays_pending.push_back('{rz: one, ry: mone, rx: 32'd1});     // saturates
    rays_pending.push_back('{rz: mone, ry: one, rx: 32'hFFFF_FFFF});
    rays_pending.push_back('{rz: 32'h7FFF_FFFF, ry: 32'h8000_0000, rx: 32'h7FFF_FFFF});
    rays_pending.push_back('{rz: 32'h8000_0000, ry: 32'h7FFF_FFFF, rx: 32'h8000_0000});
    rays_pending.push_back('{rz: 32'hFFFF_FFFF, ry: 32'hFFFF_FFFF, rx: 32'hFFFF_FFFF});
    rays_pending.push_back('{rz: 32'h0000_1000, ry: 32'h0000_1000, rx: one});
    drain();

    // Centre at the pole: every ray has a zero denominator
    write_reg(CFG_CENTER_X, 0);
    write_reg(CFG_CENTER_Y, 0);
    write_reg(CFG_CENTER_Z, one);
    write_reg(CFG_SPARE, 32'hDEAD_BEEF);
    rays_pending.push_back('{rz: one, ry: 0, rx: 0});
    rays_pending.push_back('{rz: 32'd5, ry: 32'd7, rx: 32'd3});
    drain();

    // Extreme centres
    write_reg(CFG_CENTER_X, mone);
    write_reg(CFG_CENTER_Y, mone);
    write_reg(CFG_CENTER_Z, mone);
    rays_pending.push_back('{rz: mone, ry: mone, rx: mone});
    rays_pending.push_back('{rz: one, ry: one, rx: one});
    rays_pending.push_back('{rz: 0, ry: one, rx: mone});
    push_random(80);
    drain();

    write_reg(CFG_CENTER_X, 32'h2D41_3CCD);   // about 1/sqrt(2)
    write_reg(CFG_CENTER_Y, 32'h2D41_3CCD);
    write_reg(CFG_CENTER_Z, 0);
    push_random(100);
    drain();

    // Swap the idle rates; hold the receiver off so the pipe fills
    send_idle = 64;
    recv_idle = 21;
    write_reg(CFG_CENTER_X, 32'h2000_0000);
    write_reg(CFG_CENTER_Y, 32'hD000_0000);
    write_reg(CFG_CENTER_Z, 32'h3000_0000);
    hold_left = 400;
    send_idle = 0;
    push_random(120);
    while (hold_left > 0) @(posedge clk_i);
    send_idle = 64;
    drain();

    write_reg(CFG_CENTER_X, $urandom);
    write_reg(CFG_CENTER_Y, $urandom);
    write_reg(CFG_CENTER_Z, $urandom);
    push_random(80);
    drain();

    // No idling on either side
    send_idle = 0;
    recv_idle = 0;
    write_reg(CFG_CENTER_X, 32'h7FFF_FFFF);
    write_reg(CFG_CENTER_Y, 32'h8000_0000);
    write_reg(CFG_CENTER_Z, 32'h0000_0001);
    push_random(80);
    drain();

    write_reg(CFG_CENTER_X, 32'h3A00_0000);
    write_reg(CFG_CENTER_Y, 32'h0800_0000);
    write_reg(CFG_CENTER_Z, 32'hF000_0000);
    push_random(90);
    drain();

    repeat (PIPE_LAT) @(posedge clk_i);
    if (n_err == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
`default_nettype wire
